@@ hw/rtl/cube_map_face_select_unit_defines.svh @@
// Assertion macros shared by the cube map face select unit.
`ifndef CUBE_MAP_FACE_SELECT_UNIT_DEFINES_SVH
`define CUBE_MAP_FACE_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CMFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CMFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cmfs_pkg.sv @@
// Shared constants, face codes and stage payload types of the cube map face select unit.
package cmfs_pkg;

    localparam int COMP_BITS  = 16;
    localparam int COORD_BITS = 16;

    // One fractional quotient bit is resolved per divider step stage.
    localparam int NUM_STEPS = COORD_BITS - 1;

    localparam int S_TDATA_W  = ((3 * COMP_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = 3 + 2 * COORD_BITS;
    localparam int M_TDATA_W  = ((M_DATA_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_DATA_W;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    localparam logic [COORD_BITS-1:0] COORD_HALF = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX  = {COORD_BITS{1'b1}};

    // Result of the face selection stage.
    typedef struct packed {
        logic                        zero;
        logic [2:0]                  face;
        logic [COMP_BITS-1:0]        depth;
        logic signed [COMP_BITS:0]   du;
        logic signed [COMP_BITS:0]   dv;
    } sel_t;

    // Partial state of the two coordinate divisions.
    typedef struct packed {
        logic                        zero;
        logic [2:0]                  face;
        logic                        sat_u;
        logic                        sat_v;
        logic [COMP_BITS-1:0]        depth;
        logic [COMP_BITS-1:0]        rem_u;
        logic [COMP_BITS-1:0]        rem_v;
        logic [COORD_BITS-1:0]       q_u;
        logic [COORD_BITS-1:0]       q_v;
    } div_t;

endpackage

@@ hw/rtl/cmfs_select.sv @@
// Face selection stage: component magnitudes, major axis choice and minor components.
module cmfs_select
    import cmfs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        in_valid,
    input  logic signed [COMP_BITS-1:0] dir_x,
    input  logic signed [COMP_BITS-1:0] dir_y,
    input  logic signed [COMP_BITS-1:0] dir_z,
    output logic                        out_valid,
    output sel_t                        out_data
);

    logic signed [COMP_BITS:0] x_ext, y_ext, z_ext;
    logic signed [COMP_BITS:0] x_neg, y_neg, z_neg;
    logic [COMP_BITS-1:0]      ax, ay, az;
    logic                      x_pos, y_pos, z_pos;
    logic                      valid_reg;
    sel_t                      data_reg, data_next;

    assign x_ext = {dir_x[COMP_BITS-1], dir_x};
    assign y_ext = {dir_y[COMP_BITS-1], dir_y};
    assign z_ext = {dir_z[COMP_BITS-1], dir_z};
    assign x_neg = -x_ext;
    assign y_neg = -y_ext;
    assign z_neg = -z_ext;

    // The magnitude of the most negative value still fits unsigned.
    assign ax = dir_x[COMP_BITS-1] ? x_neg[COMP_BITS-1:0] : dir_x[COMP_BITS-1:0];
    assign ay = dir_y[COMP_BITS-1] ? y_neg[COMP_BITS-1:0] : dir_y[COMP_BITS-1:0];
    assign az = dir_z[COMP_BITS-1] ? z_neg[COMP_BITS-1:0] : dir_z[COMP_BITS-1:0];

    assign x_pos = !dir_x[COMP_BITS-1] && (dir_x != '0);
    assign y_pos = !dir_y[COMP_BITS-1] && (dir_y != '0);
    assign z_pos = !dir_z[COMP_BITS-1] && (dir_z != '0);

    always_comb
    begin
        data_next.zero = (ax == '0) && (ay == '0) && (az == '0);
        if ((ax >= ay) && (ax >= az))
        begin
            data_next.dv    = y_ext;
            data_next.depth = ax;
            if (x_pos)
            begin
                data_next.face = FACE_POS_X;
                data_next.du   = z_ext;
            end
            else
            begin
                data_next.face = FACE_NEG_X;
                data_next.du   = z_neg;
            end
        end
        else if (ay >= az)
        begin
            data_next.du    = x_ext;
            data_next.depth = ay;
            if (y_pos)
            begin
                data_next.face = FACE_POS_Y;
                data_next.dv   = z_ext;
            end
            else
            begin
                data_next.face = FACE_NEG_Y;
                data_next.dv   = z_neg;
            end
        end
        else
        begin
            data_next.dv    = y_ext;
            data_next.depth = az;
            if (z_pos)
            begin
                data_next.face = FACE_POS_Z;
                data_next.du   = x_neg;
            end
            else
            begin
                data_next.face = FACE_NEG_Z;
                data_next.du   = x_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/cmfs_div_init.sv @@
// Divider entry stage: numerator forming and the integer part of both quotients.
module cmfs_div_init
    import cmfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic in_valid,
    input  sel_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic signed [COMP_BITS+1:0] sum_u, sum_v;
    logic [COMP_BITS:0]          num_u, num_v, depth_ext, depth_dbl;
    logic [COMP_BITS:0]          diff_u, diff_v;
    logic                        one_u, one_v, two_u, two_v;
    logic                        valid_reg;
    div_t                        data_reg, data_next;

    // depth + minor is never negative and at most twice the depth.
    assign sum_u     = $signed({2'b00, in_data.depth}) + {in_data.du[COMP_BITS], in_data.du};
    assign sum_v     = $signed({2'b00, in_data.depth}) + {in_data.dv[COMP_BITS], in_data.dv};
    assign num_u     = sum_u[COMP_BITS:0];
    assign num_v     = sum_v[COMP_BITS:0];
    assign depth_ext = {1'b0, in_data.depth};
    assign depth_dbl = {in_data.depth, 1'b0};
    assign diff_u    = num_u - depth_ext;
    assign diff_v    = num_v - depth_ext;
    assign one_u     = num_u >= depth_ext;
    assign one_v     = num_v >= depth_ext;
    assign two_u     = num_u == depth_dbl;
    assign two_v     = num_v == depth_dbl;

    always_comb
    begin
        data_next.zero  = in_data.zero;
        data_next.face  = in_data.face;
        data_next.depth = in_data.depth;
        data_next.sat_u = two_u;
        data_next.sat_v = two_v;
        data_next.rem_u = two_u ? '0 : (one_u ? diff_u[COMP_BITS-1:0] : num_u[COMP_BITS-1:0]);
        data_next.rem_v = two_v ? '0 : (one_v ? diff_v[COMP_BITS-1:0] : num_v[COMP_BITS-1:0]);
        data_next.q_u   = {{(COORD_BITS-1){1'b0}}, one_u};
        data_next.q_v   = {{(COORD_BITS-1){1'b0}}, one_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/cmfs_div_step.sv @@
// Divider step stage: one restoring division step, one quotient bit for each coordinate.
module cmfs_div_step
    import cmfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic [COMP_BITS:0] rem2_u, rem2_v, depth_ext, diff_u, diff_v;
    logic               bit_u, bit_v;
    logic               valid_reg;
    div_t               data_reg, data_next;

    assign depth_ext = {1'b0, in_data.depth};
    assign rem2_u    = {in_data.rem_u, 1'b0};
    assign rem2_v    = {in_data.rem_v, 1'b0};
    assign diff_u    = rem2_u - depth_ext;
    assign diff_v    = rem2_v - depth_ext;
    assign bit_u     = rem2_u >= depth_ext;
    assign bit_v     = rem2_v >= depth_ext;

    always_comb
    begin
        data_next       = in_data;
        data_next.rem_u = bit_u ? diff_u[COMP_BITS-1:0] : rem2_u[COMP_BITS-1:0];
        data_next.rem_v = bit_v ? diff_v[COMP_BITS-1:0] : rem2_v[COMP_BITS-1:0];
        data_next.q_u   = {in_data.q_u[COORD_BITS-2:0], bit_u};
        data_next.q_v   = {in_data.q_v[COORD_BITS-2:0], bit_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/cube_map_face_select_unit.sv @@
// Top level of the cube map face select unit: pipeline chain, flow control and output register.
//
// The slave channel takes one direction vector per transaction: dir_x, dir_y and dir_z
// packed in s_tdata. The master channel returns one result per transaction: the face
// number and the face coordinates u and v in m_tdata, and the zero vector flag in m_tuser.
// Results leave in the order the vectors came in.
//
// The datapath is a pipeline of COORD_BITS + 2 register stages: face selection, the
// divider entry stage that forms the numerators and the integer quotient bit, one
// restoring division step per fractional coordinate bit, and the output register.
// One transaction enters per cycle while s_tready is high; the divider steps are fully
// pipelined, so throughput is one result per cycle for as long as the receiver keeps
// m_tready high.
//
// Each stage carries its own valid bit. A stage loads whenever it is empty or the stage
// after it moves on, so bubbles close up while the receiver stalls and s_tready falls
// only when every stage holds a transaction. Nothing is dropped or repeated on a stall.
//
// Reset clears all valid bits; the pipeline comes out of reset empty and ready.
module cube_map_face_select_unit
    import cmfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata fields from bit 0 up: dir_x, dir_y, dir_z, zero padding.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields from bit 0 up: face, coord_u, coord_v, zero padding.
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser fields from bit 0 up: zero_vector.
    output logic                  m_tuser
);

    `include "cube_map_face_select_unit_defines.svh"

    localparam int NUM_STAGES = NUM_STEPS + 2;

    logic signed [COMP_BITS-1:0] dir_x, dir_y, dir_z;
    sel_t                        sel_data;
    div_t                        div_data [NUM_STEPS+1];
    logic [NUM_STAGES-1:0]       stage_valid;
    logic [NUM_STAGES-1:0]       stage_load;
    logic                        out_load;

    logic                        m_valid_reg;
    logic [2:0]                  face_reg, face_next;
    logic [COORD_BITS-1:0]       coord_u_reg, coord_u_next;
    logic [COORD_BITS-1:0]       coord_v_reg, coord_v_next;
    logic                        zero_reg;

    assign dir_x = s_tdata[COMP_BITS-1:0];
    assign dir_y = s_tdata[2*COMP_BITS-1:COMP_BITS];
    assign dir_z = s_tdata[3*COMP_BITS-1:2*COMP_BITS];

    // Flow control: a stage loads when it is empty or its successor loads.
    assign out_load = !m_valid_reg || m_tready;
    assign stage_load[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || out_load;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_STAGES - 1; gi++)
        begin : g_load
            assign stage_load[gi] = !stage_valid[gi] || stage_load[gi+1];
        end
    endgenerate

    assign s_tready = stage_load[0];

    cmfs_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stage_load[0]),
        .in_valid  (s_tvalid),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .out_valid (stage_valid[0]),
        .out_data  (sel_data)
    );

    cmfs_div_init u_div_init (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stage_load[1]),
        .in_valid  (stage_valid[0]),
        .in_data   (sel_data),
        .out_valid (stage_valid[1]),
        .out_data  (div_data[0])
    );

    generate
        for (gi = 0; gi < NUM_STEPS; gi++)
        begin : g_step
            cmfs_div_step u_div_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (stage_load[gi+2]),
                .in_valid  (stage_valid[gi+1]),
                .in_data   (div_data[gi]),
                .out_valid (stage_valid[gi+2]),
                .out_data  (div_data[gi+1])
            );
        end
    endgenerate

    // A coordinate of exactly 1.0 saturates; the zero vector gives centered coordinates.
    always_comb
    begin
        face_next = div_data[NUM_STEPS].face;
        if (div_data[NUM_STEPS].zero)
        begin
            face_next    = FACE_NEG_X;
            coord_u_next = COORD_HALF;
            coord_v_next = COORD_HALF;
        end
        else
        begin
            coord_u_next = div_data[NUM_STEPS].sat_u ? COORD_MAX : div_data[NUM_STEPS].q_u;
            coord_v_next = div_data[NUM_STEPS].sat_v ? COORD_MAX : div_data[NUM_STEPS].q_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= stage_valid[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            face_reg    <= face_next;
            coord_u_reg <= coord_u_next;
            coord_v_reg <= coord_v_next;
            zero_reg    <= div_data[NUM_STEPS].zero;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, coord_v_reg, coord_u_reg, face_reg};
    assign m_tuser  = zero_reg;

    // An accepted transaction always lands in the selection stage.
    `CMFS_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, stage_valid[0], "accepted transaction lost at entry")
    // The input stalls exactly when every stage is full and the output is stalled.
    `CMFS_ASSERT_IMPL(a_ready_full, 1'b1, s_tready == (!(&stage_valid) || out_load), "s_tready disagrees with pipeline occupancy")
    // A zero vector result always reports the negative x face with centered coordinates.
    `CMFS_ASSERT_IMPL(a_zero_result, m_tvalid && m_tuser, (face_reg == FACE_NEG_X) && (coord_u_reg == COORD_HALF) && (coord_v_reg == COORD_HALF), "zero vector result malformed")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the cube map face select unit.
module testbench;
    import cmfs_pkg::*;

    // Clock, run length and flow-control shaping.
    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_DIRS  = 1200;
    // No idling on either side during the last transactions of the run.
    localparam int TAIL_DIRS    = 150;
    // The pipeline is 18 stages deep, so this covers any straggling result.
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 120;
    localparam int REPORT_MAX   = 30;
    localparam int MAG_MAX      = 1 << (COMP_BITS - 1);

    // One expected or observed result transaction.
    typedef struct packed {
        logic [2:0]            face;
        logic [COORD_BITS-1:0] u;
        logic [COORD_BITS-1:0] v;
        logic                  zero;
    } face_hit_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata fields from bit 0 up: dir_x, dir_y, dir_z, zero padding.
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata fields from bit 0 up: face, coord_u, coord_v, zero padding.
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser fields from bit 0 up: zero_vector.
    logic                 m_tuser;

    cube_map_face_select_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // Direction vectors waiting to be offered, and the face lookups still owed by the DUT.
    logic [S_TDATA_W-1:0] dir_queue[$];
    face_hit_t            hits_due[$];

    int        dir_total = 0;
    int        dirs_taken = 0;
    int        hits_seen = 0;
    int        errors = 0;
    int        cycles = 0;
    int        zero_seen = 0;
    int        sat_seen = 0;
    int        stall_cycles = 0;
    int        face_seen[6];
    logic      in_taken = 1'b0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        tx_mode = 0;
    int        rx_mode = 0;
    int        hold_left = 0;
    logic      hold_done = 1'b0;
    face_hit_t got_hit;
    face_hit_t want_hit;

    // Face coordinate: floor(2^(COORD_BITS-1) * (depth + minor) / depth), clamped at full scale.
    // The minor magnitude never exceeds the depth, so the numerator is never negative.
    function automatic logic [COORD_BITS-1:0] scale_coord(input longint minor, input longint depth);
        longint quot;
        quot = ((depth + minor) * (longint'(1) << (COORD_BITS - 1))) / depth;
        if (quot > longint'(COORD_MAX))
            quot = longint'(COORD_MAX);
        return quot[COORD_BITS-1:0];
    endfunction

    // Picks the face of the largest-magnitude axis (ties go x, then y, then z) and its u and v.
    function automatic face_hit_t predict_face(input logic [S_TDATA_W-1:0] word);
        longint    x, y, z, ax, ay, az, du, dv, depth;
        face_hit_t hit;
        x  = longint'($signed(word[0 +: COMP_BITS]));
        y  = longint'($signed(word[COMP_BITS +: COMP_BITS]));
        z  = longint'($signed(word[2*COMP_BITS +: COMP_BITS]));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        hit.zero = 1'b0;
        if (ax == 0 && ay == 0 && az == 0) begin
            // A zero vector has no direction: fixed face -x, centered coordinates.
            hit.zero = 1'b1;
            hit.face = FACE_NEG_X;
            hit.u    = COORD_HALF;
            hit.v    = COORD_HALF;
            return hit;
        end
        if (ax >= ay && ax >= az) begin
            dv    = y;
            depth = ax;
            if (x > 0) begin
                du       = z;
                hit.face = FACE_POS_X;
            end
            else begin
                du       = -z;
                hit.face = FACE_NEG_X;
            end
        end
        else if (ay >= az) begin
            du    = x;
            depth = ay;
            if (y > 0) begin
                dv       = z;
                hit.face = FACE_POS_Y;
            end
            else begin
                dv       = -z;
                hit.face = FACE_NEG_Y;
            end
        end
        else begin
            dv    = y;
            depth = az;
            if (z > 0) begin
                du       = -x;
                hit.face = FACE_POS_Z;
            end
            else begin
                du       = x;
                hit.face = FACE_NEG_Z;
            end
        end
        hit.u = scale_coord(du, depth);
        hit.v = scale_coord(dv, depth);
        return hit;
    endfunction

    // Packs one direction into the slave tdata layout and queues it.
    task automatic add_dir(input int x, input int y, input int z);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[0 +: COMP_BITS]           = x[COMP_BITS-1:0];
        word[COMP_BITS +: COMP_BITS]   = y[COMP_BITS-1:0];
        word[2*COMP_BITS +: COMP_BITS] = z[COMP_BITS-1:0];
        dir_queue.push_back(word);
    endtask

    // Value of magnitude mag with a random sign; the full magnitude only exists as negative.
    function automatic int signed_mag(input int mag);
        if (mag >= MAG_MAX || $urandom_range(0, 1) == 1)
            return -mag;
        return mag;
    endfunction

    function automatic int any_comp();
        return int'($urandom_range(0, 2 * MAG_MAX - 1)) - MAG_MAX;
    endfunction

    function automatic int edge_comp();
        case ($urandom_range(0, 5))
            0: return -MAG_MAX;
            1: return -MAG_MAX + 1;
            2: return MAG_MAX - 1;
            3: return MAG_MAX - 2;
            4: return int'($urandom_range(0, 2)) - 1;
            default: return signed_mag(MAG_MAX - int'($urandom_range(0, 3)));
        endcase
    endfunction

    // Directed part: every face, three-way and y-z ties, saturation at both ends and the zero vector.
    task automatic build_directed();
        add_dir(0, 0, 0);
        add_dir(1, 0, 0);
        add_dir(-1, 0, 0);
        add_dir(0, 1, 0);
        add_dir(0, -1, 0);
        add_dir(0, 0, 1);
        add_dir(0, 0, -1);
        add_dir(MAG_MAX - 1, 0, 0);
        add_dir(-MAG_MAX, 0, 0);
        add_dir(0, 0, -MAG_MAX);
        // Three-way and two-way ties on the major magnitude.
        add_dir(5, 5, 5);
        add_dir(-5, 5, -5);
        add_dir(0, 7, -7);
        add_dir(0, -7, 7);
        add_dir(1, 3, -3);
        // Minor equal to major drives a coordinate to full scale or to zero.
        add_dir(100, 100, 100);
        add_dir(100, -100, -100);
        add_dir(-MAG_MAX, -MAG_MAX, -MAG_MAX);
        add_dir(-MAG_MAX, MAG_MAX - 1, -(MAG_MAX - 1));
        add_dir(MAG_MAX - 1, -MAG_MAX, 0);
        add_dir(MAG_MAX - 1, MAG_MAX - 1, -MAG_MAX);
        add_dir(-MAG_MAX, MAG_MAX - 1, MAG_MAX - 1);
        add_dir(MAG_MAX - 1, -(MAG_MAX - 1), MAG_MAX - 1);
        add_dir(-1, -1, -1);
        add_dir(3, -MAG_MAX, MAG_MAX - 1);
    endtask

    // Random part: a mix of raw vectors, tiny vectors, forced ties and edge values.
    task automatic build_random();
        int mag, minor, pick, x, y, z;
        for (int i = 0; i < RANDOM_DIRS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                add_dir(any_comp(), any_comp(), any_comp());
            end
            else if (pick < 55) begin
                add_dir(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8,
                        int'($urandom_range(0, 16)) - 8);
            end
            else if (pick < 75) begin
                // Two or three components share the largest magnitude.
                mag   = $urandom_range(1, MAG_MAX);
                minor = $urandom_range(0, mag - 1);
                x = signed_mag(mag);
                y = signed_mag(mag);
                z = signed_mag($urandom_range(0, 1) == 1 ? mag : minor);
                case ($urandom_range(0, 2))
                    0: add_dir(x, y, z);
                    1: add_dir(x, z, y);
                    default: add_dir(z, x, y);
                endcase
            end
            else if (pick < 90) begin
                add_dir(edge_comp(), edge_comp(), edge_comp());
            end
            else begin
                // Minor as large as the major, so a coordinate clamps or drops to zero.
                mag = $urandom_range(1, MAG_MAX);
                x = signed_mag(mag);
                y = signed_mag(mag);
                z = signed_mag($urandom_range(0, mag - 1));
                case ($urandom_range(0, 2))
                    0: add_dir(x, y, z);
                    1: add_dir(y, z, x);
                    default: add_dir(z, x, y);
                endcase
            end
        end
    endtask

    // Cycle counter, watchdog, and the periodic random redraw of the idling mode of each side.
    // Mode 0 leaves a side without idling until the next redraw.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles % 64 == 0) begin
            tx_mode <= $urandom_range(0, 2);
            rx_mode <= $urandom_range(0, 2);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d of %0d vectors taken, %0d results",
                     $time, cycles, dirs_taken, dir_total, hits_seen);
            $display("cube_map_face_select_unit test failed");
            $finish;
        end
    end

    // Sender: holds a vector until its transaction completes, then offers the next one,
    // sometimes after an idle burst.
    always @(negedge clk) begin
        if (rst_n && !(s_tvalid && !in_taken)) begin
            if (tx_gap > 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (dir_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end
            else if (dir_queue.size() > TAIL_DIRS && tx_mode != 0
                     && $urandom_range(0, tx_mode == 1 ? 9 : 2) == 0) begin
                tx_gap   <= $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end
            else begin
                s_tdata  <= dir_queue.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off once the run is under way.
    // The long hold keeps m_tready low far longer than the pipeline is deep, so every
    // stage fills and s_tready has to drop while the sender keeps offering vectors.
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && hits_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end
        else if (hits_seen + TAIL_DIRS < dir_total && rx_mode != 0
                 && $urandom_range(0, rx_mode == 1 ? 9 : 2) == 0) begin
            rx_gap   <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks each result transaction against the oldest expectation, then records
    // the expectation for any vector accepted at the same edge. The pipeline registers lie between
    // input and output, so a vector never matches a result at its own edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                hits_seen <= hits_seen + 1;
                got_hit.face = m_tdata[2:0];
                got_hit.u    = m_tdata[3 +: COORD_BITS];
                got_hit.v    = m_tdata[3 + COORD_BITS +: COORD_BITS];
                got_hit.zero = m_tuser;
                if (hits_due.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < REPORT_MAX)
                        $display("%0t: result with no vector outstanding: face %0d u %0d v %0d",
                                 $time, got_hit.face, got_hit.u, got_hit.v);
                end
                else begin
                    want_hit = hits_due.pop_front();
                    if (got_hit != want_hit) begin
                        errors <= errors + 1;
                        if (errors < REPORT_MAX) begin
                            if (got_hit.face != want_hit.face)
                                $display("%0t: face expected %0d actual %0d",
                                         $time, want_hit.face, got_hit.face);
                            if (got_hit.u != want_hit.u)
                                $display("%0t: coord_u expected %0d actual %0d",
                                         $time, want_hit.u, got_hit.u);
                            if (got_hit.v != want_hit.v)
                                $display("%0t: coord_v expected %0d actual %0d",
                                         $time, want_hit.v, got_hit.v);
                            if (got_hit.zero != want_hit.zero)
                                $display("%0t: zero_vector expected %0d actual %0d",
                                         $time, want_hit.zero, got_hit.zero);
                        end
                    end
                    else begin
                        if (want_hit.zero)
                            zero_seen <= zero_seen + 1;
                        if (want_hit.u == COORD_MAX || want_hit.v == COORD_MAX)
                            sat_seen <= sat_seen + 1;
                        if (want_hit.face < 6)
                            face_seen[want_hit.face] <= face_seen[want_hit.face] + 1;
                    end
                end
            end
            if (s_tvalid && !s_tready)
                stall_cycles <= stall_cycles + 1;
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                dirs_taken <= dirs_taken + 1;
                hits_due.push_back(predict_face(s_tdata));
            end
        end
    end

    // Sequencing: build the stimulus, release reset, wait for every vector to be taken and
    // every result to come back, then give the pipeline time to show any extra result.
    initial begin
        for (int f = 0; f < 6; f++)
            face_seen[f] = 0;
        build_directed();
        build_random();
        dir_total = dir_queue.size();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (dirs_taken != dir_total)
            @(posedge clk);
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d direction vectors: %0d zero vectors, %0d with a clamped coordinate.",
                 dir_total, zero_seen, sat_seen);
        $display("Faces +x %0d -x %0d +y %0d -y %0d +z %0d -z %0d; input held off %0d cycles.",
                 face_seen[0], face_seen[1], face_seen[2], face_seen[3], face_seen[4],
                 face_seen[5], stall_cycles);
        if (errors == 0 && hits_due.size() == 0)
            $display("cube_map_face_select_unit test passed");
        else
            $display("cube_map_face_select_unit test failed");
        $finish;
    end

endmodule
